/* src/urb_pkg.sv */
package urb_pkg;

    localparam int URB_FIFO_DEPTH    = 16;
    localparam int URB_TIMEOUT_CHARS = 4;

    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_READ  = 3'd1,
        ACT_WRITE = 3'd2,
        ACT_RX    = 3'd3,
        ACT_TXRDY = 3'd4,
        ACT_MODEM = 3'd5
    } action_t;

    localparam logic [2:0] OFF_RBR = 3'd0;
    localparam logic [2:0] OFF_IER = 3'd1;
    localparam logic [2:0] OFF_IIR = 3'd2;
    localparam logic [2:0] OFF_LCR = 3'd3;
    localparam logic [2:0] OFF_MCR = 3'd4;
    localparam logic [2:0] OFF_LSR = 3'd5;
    localparam logic [2:0] OFF_MSR = 3'd6;
    localparam logic [2:0] OFF_SCR = 3'd7;

    localparam logic [3:0] IIR_LINE    = 4'h6;
    localparam logic [3:0] IIR_DATA    = 4'h4;
    localparam logic [3:0] IIR_TIMEOUT = 4'hc;
    localparam logic [3:0] IIR_THRE    = 4'h2;
    localparam logic [3:0] IIR_MODEM   = 4'h0;
    localparam logic [3:0] IIR_NONE    = 4'h1;

    // Receive trigger level for the FCR trigger code.
    function automatic logic [3:0] trig_level(input logic [1:0] code);
        logic [3:0] t;
        case (code)
            2'd0:    t = 4'd1;
            2'd1:    t = 4'd4;
            2'd2:    t = 4'd8;
            default: t = 4'd14;
        endcase
        return t;
    endfunction

    // Returns {deltas, pins} after the modem pins take a new value.
    function automatic logic [7:0] modem_update(input logic [3:0] now, input logic [3:0] deltas,
                                                input logic [3:0] v);
        logic [3:0] d;
        d = (now ^ v) & 4'b1011;
        if (now[2] && !v[2])
        begin
            d[2] = 1'b1;
        end
        return {deltas | d, v};
    endfunction

    // Highest-priority pending source.
    function automatic logic [3:0] iir_code(input logic [3:0] ier, input logic line_pend,
                                            input logic data_pend, input logic to_pend,
                                            input logic thre, input logic modem_pend);
        logic [3:0] c;
        if (ier[2] && line_pend)
        begin
            c = IIR_LINE;
        end
        else if (ier[0] && data_pend)
        begin
            c = IIR_DATA;
        end
        else if (ier[0] && to_pend)
        begin
            c = IIR_TIMEOUT;
        end
        else if (ier[1] && thre)
        begin
            c = IIR_THRE;
        end
        else if (ier[3] && modem_pend)
        begin
            c = IIR_MODEM;
        end
        else
        begin
            c = IIR_NONE;
        end
        return c;
    endfunction

endpackage

/* src/urb_ram.sv */
module urb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* src/uart_register_block_core.sv */
// Channel   Signals                                             Handshake
// item      action reg_offset write_data rx_byte rx_flags       item_valid / item_ready
//           modem_inputs
// result    read_data irq tx_valid tx_byte modem_outputs        result_valid / result_ready
//
// Every transaction is processed in the cycle it is accepted, so one item per cycle is
// sustained while result_ready stays high; the result sits in an output register from the next cycle.
// The FIFO storage is in synchronous RAMs addressed by the next head pointer, so the head
// entries are always registered and ready when the next transaction arrives.
// item_ready drops only while a result is held and result_ready is low.
// Reset is asynchronous and clears all control state; FIFO entries need no clearing.
module uart_register_block_core #(
    parameter int FIFO_DEPTH    = urb_pkg::URB_FIFO_DEPTH,
    parameter int TIMEOUT_CHARS = urb_pkg::URB_TIMEOUT_CHARS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [2:0] action,
    input  logic [2:0] reg_offset,
    input  logic [7:0] write_data,
    input  logic [7:0] rx_byte,
    input  logic [2:0] rx_flags,
    input  logic [3:0] modem_inputs,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] read_data,
    output logic       irq,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic [3:0] modem_outputs
);
    import urb_pkg::*;

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int TW = (CW > 4) ? CW : 4;
    localparam logic [2:0] TO_LIMIT = 3'(TIMEOUT_CHARS);

    // Architectural state.
    logic [CW-1:0] rx_count_reg, rx_count_next;
    logic [AW-1:0] rx_head_reg, rx_head_next;
    logic [CW-1:0] tx_count_reg, tx_count_next;
    logic [AW-1:0] tx_head_reg, tx_head_next;
    logic [3:0]    ier_reg, ier_next;
    logic [7:0]    lcr_reg, lcr_next;
    logic [4:0]    mcr_reg, mcr_next;
    logic [15:0]   div_reg, div_next;
    logic [7:0]    scr_reg, scr_next;
    logic [2:0]    fmode_reg, fmode_next;
    logic          overrun_reg, overrun_next;
    logic [CW-1:0] rx_err_reg, rx_err_next;
    logic          thre_reg, thre_next;
    logic [3:0]    msr_now_reg, msr_now_next;
    logic [3:0]    msr_delta_reg, msr_delta_next;
    logic [2:0]    idle_reg, idle_next;

    // Output register.
    logic          out_valid_reg;
    logic [7:0]    rd_reg, rd_next;
    logic          irq_reg, irq_next;
    logic          txv_reg, txv_next;
    logic [7:0]    txb_reg, txb_next;
    logic [3:0]    mo_reg, mo_next;

    // RAM ports and head-entry forwarding.
    logic          rx_we, tx_we;
    logic [AW-1:0] rx_waddr, tx_waddr;
    logic [10:0]   rx_wdata;
    logic [7:0]    tx_wdata;
    logic [AW-1:0] rx_raddr0, rx_raddr1, tx_raddr;
    logic [10:0]   rx_q0, rx_q1;
    logic [7:0]    tx_q;
    logic          fwd0_reg, fwd1_reg, fwdt_reg;
    logic [10:0]   fwd_rx_reg;
    logic [7:0]    fwd_tx_reg;
    logic [10:0]   rx_hd0, rx_hd1;
    logic [7:0]    tx_hd;

    logic accept;

    assign item_ready = !out_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;

    assign rx_hd0 = fwd0_reg ? fwd_rx_reg : rx_q0;
    assign rx_hd1 = fwd1_reg ? fwd_rx_reg : rx_q1;
    assign tx_hd  = fwdt_reg ? fwd_tx_reg : tx_q;

    function automatic logic [AW-1:0] addr_add(input logic [AW-1:0] h, input logic [CW-1:0] c);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(c);
        if (s >= (CW+1)'(FIFO_DEPTH))
        begin
            s = s - (CW+1)'(FIFO_DEPTH);
        end
        return AW'(s);
    endfunction

    // Returns {timeout pending, data pending} for a given receive state.
    function automatic logic [1:0] rx_pend(input logic [CW-1:0] cnt, input logic [2:0] fm,
                                           input logic [2:0] idle);
        logic [TW-1:0] t;
        logic [CW-1:0] trig;
        logic          dp;
        logic          tp;
        t = TW'(trig_level(fm[2:1]));
        if (t > TW'(FIFO_DEPTH))
        begin
            trig = CW'(FIFO_DEPTH);
        end
        else
        begin
            trig = CW'(t);
        end
        dp = fm[0] ? (cnt >= trig) : (cnt != '0);
        tp = fm[0] && (cnt != '0) && (idle >= TO_LIMIT);
        return {tp, dp};
    endfunction

    always_comb
    begin
        logic [CW-1:0] depth;
        logic          fifo_en;
        logic          dlab;
        logic          loop_on;
        logic [2:0]    hflags;
        logic [1:0]    pend_cur;
        logic [1:0]    pend_nx;
        logic [3:0]    src;
        logic [2:0]    hflags_nx;
        logic          push_req;
        logic [7:0]    push_byte;
        logic [2:0]    push_flags;
        logic          push_done;
        logic          popped;
        logic          lsr_clr;
        logic          rx_clr;
        logic [7:0]    mupd;
        logic [3:0]    ls_mcr;

        rx_count_next  = rx_count_reg;
        rx_head_next   = rx_head_reg;
        tx_count_next  = tx_count_reg;
        tx_head_next   = tx_head_reg;
        ier_next       = ier_reg;
        lcr_next       = lcr_reg;
        mcr_next       = mcr_reg;
        div_next       = div_reg;
        scr_next       = scr_reg;
        fmode_next     = fmode_reg;
        overrun_next   = overrun_reg;
        rx_err_next    = rx_err_reg;
        thre_next      = thre_reg;
        msr_now_next   = msr_now_reg;
        msr_delta_next = msr_delta_reg;
        idle_next      = idle_reg;
        rd_next        = 8'h00;
        txv_next       = 1'b0;
        txb_next       = 8'h00;
        rx_we          = 1'b0;
        rx_waddr       = rx_head_reg;
        rx_wdata       = rx_hd0;
        tx_we          = 1'b0;
        tx_waddr       = tx_head_reg;
        tx_wdata       = write_data;
        push_req       = 1'b0;
        push_byte      = 8'h00;
        push_flags     = 3'b000;
        push_done      = 1'b0;
        popped         = 1'b0;
        lsr_clr        = 1'b0;
        rx_clr         = 1'b0;
        mupd           = 8'h00;
        ls_mcr         = 4'h0;

        fifo_en  = fmode_reg[0];
        depth    = fifo_en ? CW'(FIFO_DEPTH) : CW'(1);
        dlab     = lcr_reg[7];
        loop_on  = mcr_reg[4];
        hflags   = (rx_count_reg != '0) ? rx_hd0[10:8] : 3'b000;
        pend_cur = rx_pend(rx_count_reg, fmode_reg, idle_reg);
        src      = iir_code(ier_reg, overrun_reg || (hflags != 3'b000), pend_cur[0],
                            pend_cur[1], thre_reg, msr_delta_reg != 4'h0);

        case (action_t'(action))
            ACT_TICK:
            begin
                if (rx_count_reg == '0)
                begin
                    idle_next = 3'd0;
                end
                else if (fifo_en && idle_reg < TO_LIMIT)
                begin
                    idle_next = idle_reg + 3'd1;
                end
            end
            ACT_READ:
            begin
                case (reg_offset)
                    OFF_RBR:
                    begin
                        if (dlab)
                        begin
                            rd_next = div_reg[7:0];
                        end
                        else
                        begin
                            idle_next = 3'd0;
                            if (rx_count_reg != '0)
                            begin
                                rd_next = rx_hd0[7:0];
                                if (rx_hd0[10:8] != 3'b000 && rx_err_reg != '0)
                                begin
                                    rx_err_next = rx_err_reg - CW'(1);
                                end
                                rx_head_next  = addr_add(rx_head_reg, CW'(1));
                                rx_count_next = rx_count_reg - CW'(1);
                                popped        = 1'b1;
                            end
                        end
                    end
                    OFF_IER:
                    begin
                        rd_next = dlab ? div_reg[15:8] : {4'h0, ier_reg};
                    end
                    OFF_IIR:
                    begin
                        if (src == IIR_THRE)
                        begin
                            thre_next = 1'b0;
                        end
                        rd_next = {fifo_en ? 2'b11 : 2'b00, 2'b00, src};
                    end
                    OFF_LCR:
                    begin
                        rd_next = lcr_reg;
                    end
                    OFF_MCR:
                    begin
                        rd_next = {3'b000, mcr_reg};
                    end
                    OFF_LSR:
                    begin
                        rd_next = {fifo_en && (rx_err_reg != '0), tx_count_reg == '0,
                                   tx_count_reg == '0, hflags, overrun_reg,
                                   rx_count_reg != '0};
                        overrun_next = 1'b0;
                        if (hflags != 3'b000)
                        begin
                            // Clear the head entry's error flags in place.
                            rx_we    = 1'b1;
                            rx_waddr = rx_head_reg;
                            rx_wdata = {3'b000, rx_hd0[7:0]};
                            lsr_clr  = 1'b1;
                            if (rx_err_reg != '0)
                            begin
                                rx_err_next = rx_err_reg - CW'(1);
                            end
                        end
                    end
                    OFF_MSR:
                    begin
                        rd_next        = {msr_now_reg, msr_delta_reg};
                        msr_delta_next = 4'h0;
                    end
                    default:
                    begin
                        rd_next = scr_reg;
                    end
                endcase
            end
            ACT_WRITE:
            begin
                case (reg_offset)
                    OFF_RBR:
                    begin
                        if (dlab)
                        begin
                            div_next[7:0] = write_data;
                        end
                        else
                        begin
                            thre_next = 1'b0;
                            if (loop_on)
                            begin
                                push_req  = 1'b1;
                                push_byte = write_data;
                                if (tx_count_reg == '0)
                                begin
                                    thre_next = 1'b1;
                                end
                            end
                            else if (tx_count_reg < depth)
                            begin
                                tx_we         = 1'b1;
                                tx_waddr      = addr_add(tx_head_reg, tx_count_reg);
                                tx_count_next = tx_count_reg + CW'(1);
                            end
                        end
                    end
                    OFF_IER:
                    begin
                        if (dlab)
                        begin
                            div_next[15:8] = write_data;
                        end
                        else
                        begin
                            if (write_data[1] && tx_count_reg == '0)
                            begin
                                thre_next = 1'b1;
                            end
                            ier_next = write_data[3:0];
                        end
                    end
                    OFF_IIR:
                    begin
                        if (write_data[0] != fifo_en)
                        begin
                            rx_clr        = 1'b1;
                            tx_count_next = '0;
                            tx_head_next  = '0;
                            thre_next     = 1'b1;
                        end
                        if (write_data[0])
                        begin
                            if (write_data[1])
                            begin
                                rx_clr = 1'b1;
                            end
                            if (write_data[2])
                            begin
                                tx_count_next = '0;
                                tx_head_next  = '0;
                                thre_next     = 1'b1;
                            end
                            fmode_next = {write_data[7:6], 1'b1};
                        end
                        else
                        begin
                            fmode_next = {fmode_reg[2:1], 1'b0};
                        end
                    end
                    OFF_LCR:
                    begin
                        lcr_next = write_data;
                    end
                    OFF_MCR:
                    begin
                        mcr_next = write_data[4:0];
                        if (write_data[4])
                        begin
                            ls_mcr         = {write_data[3], write_data[2], write_data[0],
                                              write_data[1]};
                            mupd           = modem_update(msr_now_reg, msr_delta_reg, ls_mcr);
                            msr_delta_next = mupd[7:4];
                            msr_now_next   = mupd[3:0];
                        end
                    end
                    OFF_SCR:
                    begin
                        scr_next = write_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ACT_RX:
            begin
                if (!loop_on)
                begin
                    push_req   = 1'b1;
                    push_byte  = rx_byte;
                    push_flags = rx_flags;
                end
            end
            ACT_TXRDY:
            begin
                if (tx_count_reg != '0)
                begin
                    tx_head_next  = addr_add(tx_head_reg, CW'(1));
                    tx_count_next = tx_count_reg - CW'(1);
                    if (tx_count_reg == CW'(1))
                    begin
                        thre_next = 1'b1;
                    end
                    if (loop_on)
                    begin
                        push_req  = 1'b1;
                        push_byte = tx_hd;
                    end
                    else
                    begin
                        txv_next = 1'b1;
                        txb_next = tx_hd;
                    end
                end
            end
            ACT_MODEM:
            begin
                if (!loop_on)
                begin
                    mupd           = modem_update(msr_now_reg, msr_delta_reg, modem_inputs);
                    msr_delta_next = mupd[7:4];
                    msr_now_next   = mupd[3:0];
                end
            end
            default:
            begin
            end
        endcase

        if (rx_clr)
        begin
            rx_count_next = '0;
            rx_head_next  = '0;
            rx_err_next   = '0;
            idle_next     = 3'd0;
        end

        if (push_req)
        begin
            if (rx_count_reg >= depth)
            begin
                overrun_next = 1'b1;
            end
            else
            begin
                rx_we         = 1'b1;
                rx_waddr      = addr_add(rx_head_reg, rx_count_reg);
                rx_wdata      = {push_flags, push_byte};
                rx_count_next = rx_count_reg + CW'(1);
                idle_next     = 3'd0;
                push_done     = 1'b1;
                if (push_flags != 3'b000)
                begin
                    rx_err_next = rx_err_reg + CW'(1);
                end
            end
        end

        // Head flags as they stand after this transaction.
        if (rx_count_next == '0)
        begin
            hflags_nx = 3'b000;
        end
        else if (popped)
        begin
            hflags_nx = rx_hd1[10:8];
        end
        else if (lsr_clr)
        begin
            hflags_nx = 3'b000;
        end
        else if (push_done && rx_count_reg == '0)
        begin
            hflags_nx = push_flags;
        end
        else
        begin
            hflags_nx = hflags;
        end

        pend_nx  = rx_pend(rx_count_next, fmode_next, idle_next);
        irq_next = mcr_next[3] &&
                   (iir_code(ier_next, overrun_next || (hflags_nx != 3'b000), pend_nx[0],
                             pend_nx[1], thre_next, msr_delta_next != 4'h0) != IIR_NONE);
        mo_next  = mcr_next[4] ? 4'h0 : mcr_next[3:0];
    end

    // Read addresses follow the head pointers the next transaction will see.
    assign rx_raddr0 = accept ? rx_head_next : rx_head_reg;
    assign rx_raddr1 = addr_add(rx_raddr0, CW'(1));
    assign tx_raddr  = accept ? tx_head_next : tx_head_reg;

    // Two mirrored copies of the receive store give the head and the entry behind it.
    urb_ram #(.WIDTH(11), .DEPTH(FIFO_DEPTH)) u_rx_ram0 (
        .clk   (clk),
        .we    (accept && rx_we),
        .waddr (rx_waddr),
        .wdata (rx_wdata),
        .raddr (rx_raddr0),
        .rdata (rx_q0)
    );

    urb_ram #(.WIDTH(11), .DEPTH(FIFO_DEPTH)) u_rx_ram1 (
        .clk   (clk),
        .we    (accept && rx_we),
        .waddr (rx_waddr),
        .wdata (rx_wdata),
        .raddr (rx_raddr1),
        .rdata (rx_q1)
    );

    urb_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_tx_ram (
        .clk   (clk),
        .we    (accept && tx_we),
        .waddr (tx_waddr),
        .wdata (tx_wdata),
        .raddr (tx_raddr),
        .rdata (tx_q)
    );

    // A write to an entry being read in the same cycle is forwarded around the RAM.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd0_reg <= 1'b0;
            fwd1_reg <= 1'b0;
            fwdt_reg <= 1'b0;
        end
        else
        begin
            fwd0_reg <= accept && rx_we && (rx_waddr == rx_raddr0);
            fwd1_reg <= accept && rx_we && (rx_waddr == rx_raddr1);
            fwdt_reg <= accept && tx_we && (tx_waddr == tx_raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_rx_reg <= rx_wdata;
        fwd_tx_reg <= tx_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_count_reg  <= '0;
            rx_head_reg   <= '0;
            tx_count_reg  <= '0;
            tx_head_reg   <= '0;
            ier_reg       <= 4'h0;
            lcr_reg       <= 8'h00;
            mcr_reg       <= 5'h00;
            div_reg       <= 16'h0000;
            scr_reg       <= 8'h00;
            fmode_reg     <= 3'b000;
            overrun_reg   <= 1'b0;
            rx_err_reg    <= '0;
            thre_reg      <= 1'b0;
            msr_now_reg   <= 4'h0;
            msr_delta_reg <= 4'h0;
            idle_reg      <= 3'd0;
        end
        else if (accept)
        begin
            rx_count_reg  <= rx_count_next;
            rx_head_reg   <= rx_head_next;
            tx_count_reg  <= tx_count_next;
            tx_head_reg   <= tx_head_next;
            ier_reg       <= ier_next;
            lcr_reg       <= lcr_next;
            mcr_reg       <= mcr_next;
            div_reg       <= div_next;
            scr_reg       <= scr_next;
            fmode_reg     <= fmode_next;
            overrun_reg   <= overrun_next;
            rx_err_reg    <= rx_err_next;
            thre_reg      <= thre_next;
            msr_now_reg   <= msr_now_next;
            msr_delta_reg <= msr_delta_next;
            idle_reg      <= idle_next;
        end
    end

    // The result register frees up as soon as the downstream side takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            out_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg  <= rd_next;
            irq_reg <= irq_next;
            txv_reg <= txv_next;
            txb_reg <= txb_next;
            mo_reg  <= mo_next;
        end
    end

    assign result_valid  = out_valid_reg;
    assign read_data     = rd_reg;
    assign irq           = irq_reg;
    assign tx_valid      = txv_reg;
    assign tx_byte       = txb_reg;
    assign modem_outputs = mo_reg;

    a_rx_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        rx_count_reg <= CW'(FIFO_DEPTH))
        else $error("receive count exceeds FIFO depth");

    a_tx_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        tx_count_reg <= CW'(FIFO_DEPTH))
        else $error("transmit count exceeds FIFO depth");

    a_err_bound : assert property (@(posedge clk) disable iff (!rst_n)
        rx_err_reg <= rx_count_reg)
        else $error("error entry count exceeds queued entries");

    a_non_fifo_depth : assert property (@(posedge clk) disable iff (!rst_n)
        !fmode_reg[0] |-> (rx_count_reg <= CW'(1) && tx_count_reg <= CW'(1)))
        else $error("more than one entry queued with FIFOs off");

    a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid)
        else $error("accepted transaction produced no result");

endmodule
